FILE: sv/integer_to_ascii_formatter_defines.svh
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_defines
// Assertion macros used by the formatter checker. Each expects clk and
// arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication
`define ITAF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ITAF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg
// Widths, codes, controller states, command/status types and the digit
// character function of the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package itaf_pkg;

	localparam int VALUE_WIDTH  = 32;
	localparam int IN_WIDTH     = 32;
	localparam int OPCODE_WIDTH = 2;
	localparam int CHAR_WIDTH   = 8;

	localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int DIG_W      = DEC_DIGITS * 4;
	localparam int HEX_SHIFT  = (DEC_DIGITS - HEX_DIGITS) * 4;
	localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [DIG_W-1:0]       digits_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [CHAR_WIDTH-1:0]  char_t;
	typedef logic [OPCODE_WIDTH-1:0] opcode_t;

	// any other opcode prints hexadecimal
	localparam opcode_t OP_UDEC = 2'd0;
	localparam opcode_t OP_SDEC = 2'd1;

	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_X     = 8'h78;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_A     = 8'h41;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_PRE0,
		ST_PRE1,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic shift_bit;
		logic set_digits;
		logic emit_pre0;
		logic emit_pre1;
		logic skip_digit;
		logic emit_digit;
	} dp_cmd_t;

	typedef struct packed {
		logic hex;
		logic neg;
		logic cnt_one;
		logic top_zero;
		logic slot_free;
	} dp_sts_t;

	function automatic char_t digit_char(input logic [3:0] d);
		char_t c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'd0, d};
		end else begin
			c = CH_A + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

FILE: sv/itaf_in_if.sv
// ----------------------------------------------------------------------------
// itaf_in_if
// Number channel: value and format opcode with valid/ready.
// ----------------------------------------------------------------------------
interface itaf_in_if;
	logic                            valid;
	logic                            ready;
	logic [itaf_pkg::IN_WIDTH-1:0]   value;
	logic [itaf_pkg::OPCODE_WIDTH-1:0] opcode;

	modport source (output valid, value, opcode, input ready);
	modport sink   (input valid, value, opcode, output ready);
endinterface

FILE: sv/itaf_out_if.sv
// ----------------------------------------------------------------------------
// itaf_out_if
// Character channel: one ASCII code and a last flag with valid/ready.
// ----------------------------------------------------------------------------
interface itaf_out_if;
	logic                            valid;
	logic                            ready;
	logic [itaf_pkg::CHAR_WIDTH-1:0] out_char;
	logic                            last_char;

	modport source (output valid, out_char, last_char, input ready);
	modport sink   (input valid, out_char, last_char, output ready);
endinterface

FILE: sv/itaf_ctrl.sv
// ----------------------------------------------------------------------------
// itaf_ctrl
// Sequencer: accept, bit-serial conversion, prefix, leading-zero drop and
// character emission.
// ----------------------------------------------------------------------------
module itaf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  itaf_pkg::dp_sts_t sts,
	output itaf_pkg::dp_cmd_t cmd
);

	itaf_pkg::state_t state_q;
	itaf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itaf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			itaf_pkg::ST_IDLE: begin
				if (in_valid) state_d = itaf_pkg::ST_CONV;
			end
			itaf_pkg::ST_CONV: begin
				if (sts.hex) begin
					state_d = itaf_pkg::ST_PRE0;
				end else if (sts.cnt_one) begin
					state_d = sts.neg ? itaf_pkg::ST_PRE0 : itaf_pkg::ST_SKIP;
				end
			end
			itaf_pkg::ST_PRE0: begin
				if (sts.slot_free) state_d = sts.hex ? itaf_pkg::ST_PRE1 : itaf_pkg::ST_SKIP;
			end
			itaf_pkg::ST_PRE1: begin
				if (sts.slot_free) state_d = itaf_pkg::ST_SKIP;
			end
			itaf_pkg::ST_SKIP: begin
				if (!sts.top_zero || sts.cnt_one) state_d = itaf_pkg::ST_EMIT;
			end
			itaf_pkg::ST_EMIT: begin
				if (sts.slot_free && sts.cnt_one) state_d = itaf_pkg::ST_IDLE;
			end
			default: state_d = itaf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			itaf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			itaf_pkg::ST_CONV: begin
				cmd.shift_bit  = !sts.hex;
				cmd.set_digits = !sts.hex && sts.cnt_one;
			end
			itaf_pkg::ST_PRE0: cmd.emit_pre0 = sts.slot_free;
			itaf_pkg::ST_PRE1: cmd.emit_pre1 = sts.slot_free;
			itaf_pkg::ST_SKIP: cmd.skip_digit = sts.top_zero && !sts.cnt_one;
			itaf_pkg::ST_EMIT: cmd.emit_digit = sts.slot_free;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: sv/itaf_dp.sv
// ----------------------------------------------------------------------------
// itaf_dp
// Datapath: magnitude and sign capture, shift-and-add-3 binary to BCD,
// digit shifter and the output character register.
// ----------------------------------------------------------------------------
module itaf_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  itaf_pkg::dp_cmd_t              cmd,
	output itaf_pkg::dp_sts_t              sts,
	input  logic [itaf_pkg::IN_WIDTH-1:0]  in_value,
	input  itaf_pkg::opcode_t              in_opcode,
	output logic                           out_valid,
	output itaf_pkg::char_t                out_char,
	output logic                           out_last,
	input  logic                           out_ready
);

	itaf_pkg::value_t  raw;
	itaf_pkg::value_t  mag;
	logic              in_hex;
	logic              in_neg;

	itaf_pkg::value_t  bin_q;
	itaf_pkg::digits_t bcd_q;
	itaf_pkg::digits_t adj;
	itaf_pkg::cnt_t    cnt_q;
	logic              hex_q;
	logic              neg_q;

	logic              out_valid_q;
	itaf_pkg::char_t   out_char_q;
	logic              out_last_q;
	logic              wr;
	itaf_pkg::char_t   ch;

	assign raw    = itaf_pkg::value_t'(in_value);
	assign in_hex = (in_opcode != itaf_pkg::OP_UDEC) && (in_opcode != itaf_pkg::OP_SDEC);
	assign in_neg = (in_opcode == itaf_pkg::OP_SDEC) && raw[itaf_pkg::VALUE_WIDTH-1];
	assign mag    = in_neg ? itaf_pkg::value_t'(~raw + itaf_pkg::value_t'(1)) : raw;

	always_comb begin
		adj = bcd_q;
		for (int i = 0; i < itaf_pkg::DEC_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= mag;
			hex_q <= in_hex;
			neg_q <= in_neg;
			if (in_hex) begin
				bcd_q <= itaf_pkg::digits_t'(mag) << itaf_pkg::HEX_SHIFT;
				cnt_q <= itaf_pkg::cnt_t'(itaf_pkg::HEX_DIGITS);
			end else begin
				bcd_q <= '0;
				cnt_q <= itaf_pkg::cnt_t'(itaf_pkg::VALUE_WIDTH);
			end
		end else if (cmd.shift_bit) begin
			bcd_q <= {adj[itaf_pkg::DIG_W-2:0], bin_q[itaf_pkg::VALUE_WIDTH-1]};
			bin_q <= bin_q << 1;
			cnt_q <= cmd.set_digits ? itaf_pkg::cnt_t'(itaf_pkg::DEC_DIGITS)
			                        : cnt_q - itaf_pkg::cnt_t'(1);
		end else if (cmd.skip_digit || cmd.emit_digit) begin
			bcd_q <= bcd_q << 4;
			cnt_q <= cnt_q - itaf_pkg::cnt_t'(1);
		end
	end

	assign sts.hex       = hex_q;
	assign sts.neg       = neg_q;
	assign sts.cnt_one   = (cnt_q == itaf_pkg::cnt_t'(1));
	assign sts.top_zero  = (bcd_q[itaf_pkg::DIG_W-1 -: 4] == 4'd0);
	assign sts.slot_free = !out_valid_q || out_ready;

	assign wr = cmd.emit_pre0 || cmd.emit_pre1 || cmd.emit_digit;

	always_comb begin
		if (cmd.emit_pre0) begin
			ch = hex_q ? itaf_pkg::CH_ZERO : itaf_pkg::CH_MINUS;
		end else if (cmd.emit_pre1) begin
			ch = itaf_pkg::CH_X;
		end else begin
			ch = itaf_pkg::digit_char(bcd_q[itaf_pkg::DIG_W-1 -: 4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			out_char_q <= ch;
			out_last_q <= cmd.emit_digit && sts.cnt_one;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

FILE: sv/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Prints one number as ASCII characters: unsigned decimal, signed decimal or
// 0x-prefixed upper-case hexadecimal, leading zeros dropped.
//
//   port     dir   payload                      transfer
//   number   in    value[31:0], opcode[1:0]     valid & ready
//   chars    out   out_char[7:0], last_char     valid & ready
//
// Decimal: accept, then shift-and-add-3 over all VALUE_WIDTH bits (one bit per
// cycle in the BCD converter), a '-' for a negative value, then the dropped
// leading zeros one by one, the start of emission and each character.
// Hex: no conversion; the 0x prefix, then the dropped leading zeros and the digits.
// Output stalls hold the sequencer at the next character; a finished last
// character may wait in the output register while the next number is taken.
// Reset clears the sequencer and the output valid flag only.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
	input  logic       clk,
	input  logic       arst_n,
	itaf_in_if.sink    number,
	itaf_out_if.source chars
);

	itaf_pkg::dp_cmd_t cmd;
	itaf_pkg::dp_sts_t sts;

	itaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (number.valid),
		.in_ready (number.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	itaf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_value  (number.value),
		.in_opcode (number.opcode),
		.out_valid (chars.valid),
		.out_char  (chars.out_char),
		.out_last  (chars.last_char),
		.out_ready (chars.ready)
	);

endmodule

FILE: sv/itaf_checker.sv
// ----------------------------------------------------------------------------
// itaf_checker
// Port-level checks of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_defines.svh"

module itaf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       num_valid,
	input logic       num_ready,
	input logic       chr_valid,
	input logic       chr_ready,
	input logic [7:0] chr_char,
	input logic       chr_last
);

	`ITAF_ASSERT_NXT(a_chr_hold, chr_valid && !chr_ready, chr_valid && $stable(chr_char) && $stable(chr_last), "character changed while stalled")
	`ITAF_ASSERT_NXT(a_num_busy, num_valid && num_ready, !num_ready, "number taken while another is in progress")
	`ITAF_ASSERT_NXT(a_num_clean, num_valid && num_ready, !chr_valid || chr_last, "character of a new number appeared too early")
	`ITAF_ASSERT_IMP(a_mid_busy, chr_valid && !chr_last, !num_ready, "ready for a number before its last character")

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.num_valid (number.valid),
	.num_ready (number.ready),
	.chr_valid (chars.valid),
	.chr_ready (chars.ready),
	.chr_char  (chars.out_char),
	.chr_last  (chars.last_char)
);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for integer_to_ascii_formatter. Every accepted number is
// rendered into its expected character stream (unsigned, signed or hex with
// 0x prefix) and each character transfer is matched against the oldest
// expected character and its last flag. Directed corner values come first,
// then random numbers shaped around digit-count and sign boundaries, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import itaf_pkg::*;

	localparam opcode_t OP_HEX     = 2'd2;
	localparam opcode_t OP_HEX_ALT = 2'd3;

	typedef struct packed {
		char_t code;
		logic  last;
	} glyph_t;

	class ascii_scoreboard;
		glyph_t expected_chars[$];
		int     mismatches;

		function void note_number(value_t v, opcode_t op);
			string  glyphs;
			value_t mag;
			value_t radix;
			char_t  digits[$];
			glyph_t g;
			glyphs = "0123456789ABCDEF";
			mag = v;
			radix = 10;
			if (op == OP_UDEC || op == OP_SDEC) begin
				if (op == OP_SDEC && mag[VALUE_WIDTH-1]) begin
					g.code = CH_MINUS;
					g.last = 1'b0;
					expected_chars.push_back(g);
					mag = -mag;
				end
			end else begin
				radix = 16;
				g.last = 1'b0;
				g.code = CH_ZERO;
				expected_chars.push_back(g);
				g.code = CH_X;
				expected_chars.push_back(g);
			end
			do begin
				digits.push_front(char_t'(glyphs[mag % radix]));
				mag = mag / radix;
			end while (mag != 0);
			foreach (digits[i]) begin
				g.code = digits[i];
				g.last = (i == digits.size() - 1);
				expected_chars.push_back(g);
			end
		endfunction

		function void check_char(char_t code, logic last);
			glyph_t want;
			if (expected_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected char: got %h last %b", code, last);
				return;
			end
			want = expected_chars.pop_front();
			if (want.code !== code || want.last !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("char mismatch: expected %h last %b, got %h last %b",
						want.code, want.last, code, last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic steady;

	itaf_in_if  number_if();
	itaf_out_if chars_if();

	ascii_scoreboard board = new();

	integer_to_ascii_formatter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number_if),
		.chars  (chars_if)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		chars_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			chars_if.ready <= steady || ($urandom_range(0, 99) >= 9);
		end
	end

	always @(posedge clk) begin
		if (arst_n && chars_if.valid && chars_if.ready)
			board.check_char(chars_if.out_char, chars_if.last_char);
	end

	task automatic send_number(value_t v, opcode_t op);
		if (!steady && $urandom_range(0, 99) < 25) begin
			number_if.valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
		number_if.valid  <= 1'b1;
		number_if.value  <= v;
		number_if.opcode <= op;
		do @(posedge clk); while (!number_if.ready);
		board.note_number(v, op);
	endtask

	task automatic drain_chars();
		number_if.valid <= 1'b0;
		while (board.expected_chars.size() != 0) @(posedge clk);
	endtask

	function automatic value_t pick_value();
		value_t p;
		p = 1;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 99);
			2: return $urandom >> $urandom_range(0, 31);
			3: begin
				repeat ($urandom_range(0, 9)) p = p * 10;
				return p + $urandom_range(0, 2) - 1;
			end
			4: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'hFFFF_FFFF)
				+ $urandom_range(0, 4) - 2;
			default: return value_t'($urandom_range(0, 15)) << (4 * $urandom_range(0, 7));
		endcase
	endfunction

	initial begin
		int spins;
		steady = 1'b0;
		arst_n = 1'b0;
		number_if.valid  <= 1'b0;
		number_if.value  <= '0;
		number_if.opcode <= OP_UDEC;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_number(32'd0, OP_UDEC);
		send_number(32'd0, OP_SDEC);
		send_number(32'd0, OP_HEX);
		send_number(32'd0, OP_HEX_ALT);
		send_number(32'hFFFF_FFFF, OP_UDEC);
		send_number(32'hFFFF_FFFF, OP_SDEC);
		send_number(32'hFFFF_FFFF, OP_HEX);
		send_number(32'h8000_0000, OP_SDEC);
		send_number(32'h8000_0000, OP_UDEC);
		send_number(32'h8000_0001, OP_SDEC);
		send_number(32'h7FFF_FFFF, OP_SDEC);
		send_number(32'd1000000000, OP_UDEC);
		send_number(32'd999999999, OP_UDEC);
		send_number(32'hC465_3600, OP_SDEC);
		send_number(32'd9, OP_UDEC);
		send_number(32'd10, OP_SDEC);
		send_number(32'h1000_0000, OP_HEX);
		send_number(32'h0FFF_FFFF, OP_HEX_ALT);
		send_number(32'h0000_000F, OP_HEX);
		send_number(32'h0000_0010, OP_HEX);
		send_number(32'hABCD_EF01, OP_HEX_ALT);
		send_number(32'h5555_AAAA, OP_UDEC);
		drain_chars();

		for (int i = 0; i < 330; i++) begin
			steady = (i >= 100 && i < 180);
			if (i == 220)
				drain_chars();
			send_number(pick_value(), opcode_t'($urandom_range(0, 3)));
		end
		steady = 1'b0;

		number_if.valid <= 1'b0;
		spins = 0;
		while (board.expected_chars.size() != 0 && spins < 100000) begin
			@(posedge clk);
			spins++;
		end
		repeat (60) @(posedge clk);

		if (board.mismatches == 0 && board.expected_chars.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/itaf_pkg.sv
sv/itaf_in_if.sv
sv/itaf_out_if.sv
sv/itaf_ctrl.sv
sv/itaf_dp.sv
sv/integer_to_ascii_formatter.sv
sv/itaf_checker.sv
dv/testbench.sv
